>>> design/first_fit_free_list_allocator_core_macros.svh
// Assertion macros shared by the allocator core modules.
// Used by ffla_ctrl and ffla_dp; expects clk and rst_n in scope.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define FFLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ffla_pkg.sv
// Shared constants, command/status types and helpers for the allocator core.
// No dependencies; imported by ffla_ctrl, ffla_dp and the top level.
package ffla_pkg;

    localparam int unsigned POOL_BYTES  = 65536;
    localparam int unsigned POOL_WORDS  = POOL_BYTES / 8;
    localparam int unsigned WORD_AW     = $clog2(POOL_WORDS);
    localparam int unsigned WORD_W      = 33;
    localparam int unsigned WALK_W      = 13;
    localparam int unsigned MIN_PAYLOAD = 32;
    localparam int unsigned GRAIN       = 16;
    localparam int unsigned MAX_POOL    = 65536;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_BADFREE = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_ACCEPT,
        OP_A_RDTAG,
        OP_A_TAG,
        OP_A_NEXT,
        OP_A_SPLIT,
        OP_A_WHOLE,
        OP_WTAG,
        OP_RD_T,
        OP_RD_T8_CAPN,
        OP_CAPQ,
        OP_REP_WN,
        OP_REP_WQ,
        OP_REP_FIXN,
        OP_REP_FIXQ,
        OP_UNL_FIXN,
        OP_UNL_FIXQ,
        OP_PSH_W0,
        OP_PSH_W8,
        OP_PSH_FIX,
        OP_F_RDH,
        OP_F_H,
        OP_F_FTR,
        OP_F_PT,
        OP_F_NT,
        OP_F_MERGE,
        OP_SETT,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [2:0] {
        TA_P_M8,
        TA_P_S,
        TA_R_M8,
        TA_P_SZ,
        TA_PP_M8,
        TA_NP_NS
    } tag_addr_t;

    typedef enum logic [1:0] {
        TS_M,
        TS_S,
        TS_SZ
    } tag_size_t;

    typedef enum logic [1:0] {
        T_P,
        T_PP,
        T_NP
    } tsel_t;

    typedef enum logic [1:0] {
        RES_OK_ALLOC,
        RES_NOFIT,
        RES_BADFREE,
        RES_OK_FREE
    } res_t;

    typedef struct packed {
        dp_op_t    op;
        tag_addr_t ta;
        tag_size_t ts;
        logic      mark;
        tsel_t     tsel;
        res_t      res;
    } cmd_t;

    typedef struct packed {
        logic act;
        logic walk_ok;
        logic fit;
        logic split;
        logic bad_off;
        logic hbad;
        logic ftrbad;
        logic pf;
        logic nf;
        logic clr_last;
    } sts_t;

    function automatic logic [16:0] clamp_pool(input logic [16:0] v);
        logic [31:0] u;
        u = 32'(v);
        if (u < 32'd64) u = 32'd64;
        if (u > 32'(POOL_BYTES)) u = 32'(POOL_BYTES);
        if (u > 32'(MAX_POOL)) u = 32'(MAX_POOL);
        u = u & ~32'(GRAIN - 1);
        return u[16:0];
    endfunction

    function automatic logic [31:0] round_req(input logic [15:0] req);
        logic [16:0] v;
        v = (req < 16'(MIN_PAYLOAD)) ? 17'(MIN_PAYLOAD) : 17'(req);
        v = (v + 17'(GRAIN - 1)) & ~17'(GRAIN - 1);
        return 32'(v);
    endfunction

    function automatic logic [WORD_W-1:0] tag_word(input logic [31:0] size, input logic mark);
        return {mark, size};
    endfunction

    function automatic logic [WORD_W-1:0] link_word(input logic [16:0] l);
        return {16'd0, l};
    endfunction

endpackage

>>> design/first_fit_free_list_allocator_core.sv
// First-fit free-list allocator with boundary tags over a 64 KiB pool.
// Input channel (in_valid/in_stall): action 0 allocates request_size bytes,
// action 1 frees the block whose payload starts at free_offset.
// Output channel (out_valid/out_stall): one response per request, status
// (0 ok, 1 no fit, 2 invalid free) and payload_offset of an allocation.
// One request is in service at a time; a new one is taken while the previous
// response still waits in the output register.
// Allocate cost grows with each free-list node skipped, and a split costs more
// than taking a whole block; a miss walks the whole list. A rejected free ends
// early, else its cost depends on which neighbors merge. All cost comes from
// the pool memory, one tag or link word per cycle with a registered read.
// After reset, and after every cfg_wdata write on cfg_we, the pool memory is
// swept once, one word per cycle, and formatted as one free block; in_stall
// stays high during the sweep. A stalled output holds its response and the
// sequencer waits before loading the next one.
// Depends on ffla_pkg, ffla_ctrl and ffla_dp.
module first_fit_free_list_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] request_size,
    input  logic [15:0] free_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] payload_offset
);
    import ffla_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffla_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .action         (action),
        .request_size   (request_size),
        .free_offset    (free_offset),
        .cmd            (cmd),
        .sts            (sts),
        .status         (status),
        .payload_offset (payload_offset)
    );

endmodule

>>> design/ffla_dp.sv
// Allocator datapath: pool memory, block/link registers, list head, result register.
// Depends on ffla_pkg and the core macros header; driven by ffla_ctrl commands.
`include "first_fit_free_list_allocator_core_macros.svh"
module ffla_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [16:0]   cfg_wdata,
    input  logic          action,
    input  logic [15:0]   request_size,
    input  logic [15:0]   free_offset,
    input  ffla_pkg::cmd_t cmd,
    output ffla_pkg::sts_t sts,
    output logic [1:0]    status,
    output logic [15:0]   payload_offset
);
    import ffla_pkg::*;

    logic [WORD_W-1:0] mem [POOL_WORDS];
    logic [WORD_W-1:0] mem_q_reg;
    logic              rd_ok_reg;

    logic [31:0] p_reg, s_reg, sz_reg, ps_reg, ns_reg, pp_reg, np_reg, m_reg, t_reg, r_reg;
    logic [WORD_W-1:0] h_reg;
    logic [16:0] n_reg, q_reg, cur_reg;
    logic        pf_reg, nf_reg;
    logic [WALK_W-1:0]  walk_reg;
    logic [WORD_AW-1:0] clr_reg;
    logic [15:0] head_reg;
    logic        empty_reg;
    logic [16:0] used_reg;
    logic [1:0]  status_reg;
    logic [15:0] payload_reg;

    logic [WORD_W-1:0] mem_word;
    logic [31:0]       mem_size;
    logic              mem_mark;
    logic [16:0]       head_link;
    logic [31:0]       rd_addr, wr_addr, used32, clr_byte, tsel_val, tag_size;
    logic [WORD_W-1:0] wr_data, fmt_word;
    logic              wr_en;

    assign mem_word  = rd_ok_reg ? mem_q_reg : '0;
    assign mem_size  = mem_word[31:0];
    assign mem_mark  = mem_word[32];
    assign head_link = empty_reg ? 17'd0 : {1'b1, head_reg};
    assign used32    = 32'(used_reg);
    assign clr_byte  = 32'(clr_reg) << 3;

    always_comb
    begin
        unique case (cmd.tsel)
            T_PP:    tsel_val = pp_reg;
            T_NP:    tsel_val = np_reg;
            default: tsel_val = p_reg;
        endcase
        unique case (cmd.ts)
            TS_S:    tag_size = s_reg;
            TS_SZ:   tag_size = sz_reg;
            default: tag_size = m_reg;
        endcase
    end

    always_comb
    begin
        priority if (clr_byte == 32'd0)
            fmt_word = tag_word(32'd0, 1'b1);
        else if (clr_byte == 32'd8)
            fmt_word = tag_word(used32 - 32'd32, 1'b0);
        else if (clr_byte == used32 - 32'd16)
            fmt_word = tag_word(used32 - 32'd32, 1'b0);
        else if (clr_byte == used32 - 32'd8)
            fmt_word = tag_word(32'd0, 1'b1);
        else
            fmt_word = '0;
    end

    always_comb
    begin
        unique case (cmd.op)
            OP_A_RDTAG:    rd_addr = 32'(cur_reg[15:0]) - 32'd8;
            OP_A_TAG:      rd_addr = p_reg;
            OP_RD_T:       rd_addr = t_reg;
            OP_RD_T8_CAPN: rd_addr = t_reg + 32'd8;
            OP_F_RDH:      rd_addr = p_reg - 32'd8;
            OP_F_H:        rd_addr = p_reg + mem_size;
            OP_F_FTR:      rd_addr = p_reg - 32'd16;
            OP_F_PT:       rd_addr = p_reg + s_reg + 32'd8;
            default:       rd_addr = 32'd0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = 32'd0;
        wr_data = '0;
        unique case (cmd.op)
            OP_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_byte;
                wr_data = fmt_word;
            end
            OP_WTAG:
            begin
                wr_en   = 1'b1;
                wr_data = tag_word(tag_size, cmd.mark);
                unique case (cmd.ta)
                    TA_P_S:   wr_addr = p_reg + s_reg;
                    TA_R_M8:  wr_addr = r_reg - 32'd8;
                    TA_P_SZ:  wr_addr = p_reg + sz_reg;
                    TA_PP_M8: wr_addr = pp_reg - 32'd8;
                    TA_NP_NS: wr_addr = np_reg + ns_reg;
                    default:  wr_addr = p_reg - 32'd8;
                endcase
            end
            OP_REP_WN:
            begin
                wr_en   = 1'b1;
                wr_addr = r_reg;
                wr_data = link_word(n_reg);
            end
            OP_REP_WQ:
            begin
                wr_en   = 1'b1;
                wr_addr = r_reg + 32'd8;
                wr_data = link_word(q_reg);
            end
            OP_REP_FIXN:
            begin
                wr_en   = n_reg[16];
                wr_addr = 32'(n_reg[15:0]) + 32'd8;
                wr_data = link_word({1'b1, r_reg[15:0]});
            end
            OP_REP_FIXQ:
            begin
                wr_en   = q_reg[16];
                wr_addr = 32'(q_reg[15:0]);
                wr_data = link_word({1'b1, r_reg[15:0]});
            end
            OP_UNL_FIXN:
            begin
                wr_en   = n_reg[16];
                wr_addr = 32'(n_reg[15:0]) + 32'd8;
                wr_data = link_word(q_reg);
            end
            OP_UNL_FIXQ:
            begin
                wr_en   = q_reg[16];
                wr_addr = 32'(q_reg[15:0]);
                wr_data = link_word(n_reg);
            end
            OP_PSH_W0:
            begin
                wr_en   = 1'b1;
                wr_addr = t_reg;
                wr_data = link_word(head_link);
            end
            OP_PSH_W8:
            begin
                wr_en   = 1'b1;
                wr_addr = t_reg + 32'd8;
                wr_data = '0;
            end
            OP_PSH_FIX:
            begin
                wr_en   = !empty_reg;
                wr_addr = 32'(head_reg) + 32'd8;
                wr_data = link_word({1'b1, t_reg[15:0]});
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // out-of-pool reads return zero, out-of-pool writes are dropped
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr < 32'(POOL_BYTES)))
            mem[wr_addr[WORD_AW+2:3]] <= wr_data;
        mem_q_reg <= mem[rd_addr[WORD_AW+2:3]];
        rd_ok_reg <= rd_addr < 32'(POOL_BYTES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 17'(MAX_POOL);
            clr_reg   <= '0;
            head_reg  <= 16'd16;
            empty_reg <= 1'b0;
            walk_reg  <= '0;
            cur_reg   <= '0;
        end
        else if (cfg_we)
        begin
            used_reg  <= clamp_pool(cfg_wdata);
            clr_reg   <= '0;
            head_reg  <= 16'd16;
            empty_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_CLR:     clr_reg <= clr_reg + 1'b1;
                OP_ACCEPT:
                begin
                    cur_reg  <= head_link;
                    walk_reg <= '0;
                end
                OP_A_NEXT:
                begin
                    cur_reg  <= mem_word[16:0];
                    walk_reg <= walk_reg + 1'b1;
                end
                OP_REP_FIXQ:
                begin
                    if (!q_reg[16])
                    begin
                        head_reg  <= r_reg[15:0];
                        empty_reg <= 1'b0;
                    end
                end
                OP_UNL_FIXQ:
                begin
                    if (!q_reg[16])
                    begin
                        head_reg  <= n_reg[16] ? n_reg[15:0] : 16'd0;
                        empty_reg <= !n_reg[16];
                    end
                end
                OP_PSH_FIX:
                begin
                    head_reg  <= t_reg[15:0];
                    empty_reg <= 1'b0;
                end
                default:
                begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ACCEPT:
            begin
                p_reg  <= 32'(free_offset);
                sz_reg <= round_req(request_size);
            end
            OP_A_RDTAG:    p_reg <= 32'(cur_reg[15:0]);
            OP_A_TAG:      s_reg <= mem_size;
            OP_A_SPLIT:
            begin
                r_reg <= p_reg + sz_reg + 32'd16;
                t_reg <= p_reg;
                m_reg <= s_reg - sz_reg - 32'd16;
            end
            OP_A_WHOLE:
            begin
                sz_reg <= s_reg;
                t_reg  <= p_reg;
            end
            OP_RD_T8_CAPN: n_reg <= mem_word[16:0];
            OP_CAPQ:       q_reg <= mem_word[16:0];
            OP_F_H:
            begin
                h_reg <= mem_word;
                s_reg <= mem_size;
            end
            OP_F_PT:
            begin
                ps_reg <= mem_size;
                pf_reg <= !mem_mark;
            end
            OP_F_NT:
            begin
                ns_reg <= mem_size;
                nf_reg <= !mem_mark;
                pp_reg <= p_reg - 32'd16 - ps_reg;
                np_reg <= p_reg + s_reg + 32'd16;
            end
            OP_F_MERGE:
            begin
                m_reg <= s_reg + (pf_reg ? ps_reg + 32'd16 : 32'd0)
                               + (nf_reg ? ns_reg + 32'd16 : 32'd0);
                t_reg <= tsel_val;
                r_reg <= p_reg;
            end
            OP_SETT:       t_reg <= tsel_val;
            OP_RESULT:
            begin
                unique case (cmd.res)
                    RES_OK_ALLOC:
                    begin
                        status_reg  <= STAT_OK;
                        payload_reg <= p_reg[15:0];
                    end
                    RES_NOFIT:
                    begin
                        status_reg  <= STAT_NOFIT;
                        payload_reg <= 16'd0;
                    end
                    RES_BADFREE:
                    begin
                        status_reg  <= STAT_BADFREE;
                        payload_reg <= 16'd0;
                    end
                    default:
                    begin
                        status_reg  <= STAT_OK;
                        payload_reg <= 16'd0;
                    end
                endcase
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

    assign sts.act      = action;
    assign sts.walk_ok  = cur_reg[16] && (walk_reg <= WALK_W'(used_reg >> 4));
    assign sts.fit      = sz_reg <= mem_size;
    assign sts.split    = (mem_size - sz_reg) > 32'd16;
    assign sts.bad_off  = (p_reg[3:0] != 4'd0) || (p_reg < 32'd16);
    assign sts.hbad     = !mem_mark || (mem_size == 32'd0) || (mem_size[3:0] != 4'd0) ||
                          ((p_reg + mem_size + 32'd16) > used32);
    assign sts.ftrbad   = mem_word != h_reg;
    assign sts.pf       = pf_reg;
    assign sts.nf       = nf_reg;
    assign sts.clr_last = clr_reg == WORD_AW'(POOL_WORDS - 1);

    assign status         = status_reg;
    assign payload_offset = payload_reg;

    `FFLA_ASSERT_NEXT(a_cfg_reformat, cfg_we, (head_reg == 16'd16) && !empty_reg && (clr_reg == '0), "reformat did not reset list head and sweep")
    `FFLA_ASSERT_NEXT(a_walk_step, (cmd.op == OP_A_NEXT) && !cfg_we, walk_reg == $past(walk_reg) + 1'b1, "walk counter did not advance")
    `FFLA_ASSERT_NOW(a_used_range, 1'b1, (used_reg >= 17'd64) && (used_reg[3:0] == 4'd0), "pool size out of range")

endmodule

>>> design/ffla_ctrl.sv
// Allocator sequencer: walks allocate and free as steps over the pool memory.
// Depends on ffla_pkg and the core macros header; drives ffla_dp by command.
`include "first_fit_free_list_allocator_core_macros.svh"
module ffla_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  ffla_pkg::sts_t sts,
    output ffla_pkg::cmd_t cmd
);
    import ffla_pkg::*;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_RES,
        S_A_CHK, S_A_TAG, S_A_NEXT, S_A_SPLIT, S_A_SW1, S_A_SW2, S_A_WHOLE,
        S_A_FOOT, S_A_HEAD,
        S_F_CHK, S_F_H, S_F_FTR, S_F_PT, S_F_NT, S_F_MRG,
        S_F_N1, S_F_N2, S_F_P1, S_F_P2, S_F_X1, S_F_X2,
        S_F_B1, S_F_B2, S_F_B3, S_F_B4,
        S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6,
        S_U0, S_U1, S_U2, S_U3, S_U4,
        S_P0, S_P1, S_P2
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    res_t   res_reg, res_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || cfg_we;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '{op: OP_NONE, ta: TA_P_M8, ts: TS_M, mark: 1'b0,
                           tsel: T_P, res: res_reg};
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = sts.act ? S_F_CHK : S_A_CHK;
                end
            end
            S_RES:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_A_CHK:
            begin
                if (sts.walk_ok)
                begin
                    cmd.op     = OP_A_RDTAG;
                    state_next = S_A_TAG;
                end
                else
                begin
                    res_next   = RES_NOFIT;
                    state_next = S_RES;
                end
            end
            S_A_TAG:
            begin
                cmd.op = OP_A_TAG;
                priority if (!sts.fit)
                    state_next = S_A_NEXT;
                else if (sts.split)
                    state_next = S_A_SPLIT;
                else
                    state_next = S_A_WHOLE;
            end
            S_A_NEXT:
            begin
                cmd.op     = OP_A_NEXT;
                state_next = S_A_CHK;
            end
            S_A_SPLIT:
            begin
                cmd.op     = OP_A_SPLIT;
                state_next = S_A_SW1;
            end
            S_A_SW1:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_R_M8;
                cmd.ts     = TS_M;
                state_next = S_A_SW2;
            end
            S_A_SW2:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_P_S;
                cmd.ts     = TS_M;
                ret_next   = S_A_FOOT;
                state_next = S_R0;
            end
            S_A_WHOLE:
            begin
                cmd.op     = OP_A_WHOLE;
                ret_next   = S_A_FOOT;
                state_next = S_U0;
            end
            S_A_FOOT:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_P_SZ;
                cmd.ts     = TS_SZ;
                cmd.mark   = 1'b1;
                state_next = S_A_HEAD;
            end
            S_A_HEAD:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_P_M8;
                cmd.ts     = TS_SZ;
                cmd.mark   = 1'b1;
                res_next   = RES_OK_ALLOC;
                state_next = S_RES;
            end
            S_F_CHK:
            begin
                cmd.op = OP_F_RDH;
                if (sts.bad_off)
                begin
                    res_next   = RES_BADFREE;
                    state_next = S_RES;
                end
                else
                    state_next = S_F_H;
            end
            S_F_H:
            begin
                cmd.op = OP_F_H;
                if (sts.hbad)
                begin
                    res_next   = RES_BADFREE;
                    state_next = S_RES;
                end
                else
                    state_next = S_F_FTR;
            end
            S_F_FTR:
            begin
                cmd.op = OP_F_FTR;
                if (sts.ftrbad)
                begin
                    res_next   = RES_BADFREE;
                    state_next = S_RES;
                end
                else
                    state_next = S_F_PT;
            end
            S_F_PT:
            begin
                cmd.op     = OP_F_PT;
                state_next = S_F_NT;
            end
            S_F_NT:
            begin
                cmd.op     = OP_F_NT;
                state_next = S_F_MRG;
            end
            S_F_MRG:
            begin
                cmd.op   = OP_F_MERGE;
                res_next = RES_OK_FREE;
                unique case ({sts.pf, sts.nf})
                    2'b00:
                    begin
                        cmd.tsel   = T_P;
                        state_next = S_F_N1;
                    end
                    2'b10:
                    begin
                        state_next = S_F_P1;
                    end
                    2'b01:
                    begin
                        cmd.tsel   = T_NP;
                        state_next = S_F_X1;
                    end
                    default:
                    begin
                        cmd.tsel   = T_PP;
                        ret_next   = S_F_B1;
                        state_next = S_U0;
                    end
                endcase
            end
            S_F_N1:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_P_M8;
                cmd.ts     = TS_S;
                state_next = S_F_N2;
            end
            S_F_N2:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_P_S;
                cmd.ts     = TS_S;
                ret_next   = S_RES;
                state_next = S_P0;
            end
            S_F_P1:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_PP_M8;
                state_next = S_F_P2;
            end
            S_F_P2:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_P_S;
                state_next = S_RES;
            end
            S_F_X1:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_P_M8;
                state_next = S_F_X2;
            end
            S_F_X2:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_NP_NS;
                ret_next   = S_RES;
                state_next = S_R0;
            end
            S_F_B1:
            begin
                cmd.op     = OP_SETT;
                cmd.tsel   = T_NP;
                ret_next   = S_F_B2;
                state_next = S_U0;
            end
            S_F_B2:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_PP_M8;
                state_next = S_F_B3;
            end
            S_F_B3:
            begin
                cmd.op     = OP_WTAG;
                cmd.ta     = TA_NP_NS;
                state_next = S_F_B4;
            end
            S_F_B4:
            begin
                cmd.op     = OP_SETT;
                cmd.tsel   = T_PP;
                ret_next   = S_RES;
                state_next = S_P0;
            end
            // replace target t by r in the list
            S_R0:
            begin
                cmd.op     = OP_RD_T;
                state_next = S_R1;
            end
            S_R1:
            begin
                cmd.op     = OP_RD_T8_CAPN;
                state_next = S_R2;
            end
            S_R2:
            begin
                cmd.op     = OP_CAPQ;
                state_next = S_R3;
            end
            S_R3:
            begin
                cmd.op     = OP_REP_WN;
                state_next = S_R4;
            end
            S_R4:
            begin
                cmd.op     = OP_REP_WQ;
                state_next = S_R5;
            end
            S_R5:
            begin
                cmd.op     = OP_REP_FIXN;
                state_next = S_R6;
            end
            S_R6:
            begin
                cmd.op     = OP_REP_FIXQ;
                state_next = ret_reg;
            end
            // unlink target t
            S_U0:
            begin
                cmd.op     = OP_RD_T;
                state_next = S_U1;
            end
            S_U1:
            begin
                cmd.op     = OP_RD_T8_CAPN;
                state_next = S_U2;
            end
            S_U2:
            begin
                cmd.op     = OP_CAPQ;
                state_next = S_U3;
            end
            S_U3:
            begin
                cmd.op     = OP_UNL_FIXN;
                state_next = S_U4;
            end
            S_U4:
            begin
                cmd.op     = OP_UNL_FIXQ;
                state_next = ret_reg;
            end
            // push target t at list head
            S_P0:
            begin
                cmd.op     = OP_PSH_W0;
                state_next = S_P1;
            end
            S_P1:
            begin
                cmd.op     = OP_PSH_W8;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd.op     = OP_PSH_FIX;
                state_next = ret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_we)
            state_next = S_CLR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            ret_reg       <= S_RES;
            res_reg       <= RES_OK_FREE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FFLA_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, (state_reg == S_A_CHK) || (state_reg == S_F_CHK), "accepted request not dispatched")
    `FFLA_ASSERT_NEXT(a_cfg_clear, cfg_we, state_reg == S_CLR, "config write did not start the clear sweep")
    `FFLA_ASSERT_NEXT(a_res_hold, (state_reg == S_RES) && out_valid_reg && out_stall && !cfg_we, (state_reg == S_RES) && out_valid_reg, "pending result lost under stall")
    `FFLA_ASSERT_NOW(a_clr_no_out_load, state_reg == S_CLR, cmd.op != OP_RESULT, "result loaded during clear sweep")

endmodule

>>> tb/tb.sv
// Self-checking testbench for first_fit_free_list_allocator_core: requests are
// checked against an in-bench allocator predictor or a flagged directed row.
// Depends on ffla_pkg and the allocator RTL.
module tb;
    import ffla_pkg::*;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [1:0]  st;
        logic [15:0] off;
    } reply_t;

    typedef struct packed {
        logic        act;
        logic [15:0] sz;
        logic [15:0] off;
        logic        chk;
        logic [1:0]  st;
        logic [15:0] po;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [15:0] request_size = '0;
    logic [15:0] free_offset = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] payload_offset;

    reply_t      replies_due[$];
    logic [15:0] live_blocks[$];
    logic [15:0] freed_blocks[$];
    int          fails = 0;
    bit          quiet = 0;
    int          stall_cnt = 0;

    // allocator shadow state
    logic [63:0] heap_mem [POOL_WORDS];
    int unsigned heap_used;
    int unsigned head_off;
    bit          head_none;

    first_fit_free_list_allocator_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .request_size   (request_size),
        .free_offset    (free_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .payload_offset (payload_offset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] heap_rd(int unsigned a);
        return (a >> 3) < POOL_WORDS ? heap_mem[a >> 3] : 64'd0;
    endfunction

    function automatic void heap_wr(int unsigned a, logic [63:0] v);
        if ((a >> 3) < POOL_WORDS)
            heap_mem[a >> 3] = v;
    endfunction

    function automatic void put_tag(int unsigned a, int unsigned sz, bit used);
        heap_wr(a, {31'd0, used, sz});
    endfunction

    function automatic int unsigned fwd_of(int unsigned p);
        return int'(heap_rd(p) & 64'h1FFFF);
    endfunction

    function automatic int unsigned back_of(int unsigned p);
        return int'(heap_rd(p + 8) & 64'h1FFFF);
    endfunction

    function automatic void set_fwd(int unsigned p, int unsigned l);
        heap_wr(p, 64'(l & 32'h1FFFF));
    endfunction

    function automatic void set_back(int unsigned p, int unsigned l);
        heap_wr(p + 8, 64'(l & 32'h1FFFF));
    endfunction

    function automatic int unsigned head_link();
        return head_none ? 0 : ((head_off & 32'hFFFF) | 32'h10000);
    endfunction

    function automatic void set_head(int unsigned l);
        head_none = (l & 32'h10000) == 0;
        head_off = head_none ? 0 : (l & 32'hFFFF);
    endfunction

    function automatic void detach(int unsigned p);
        int unsigned n, q;
        n = fwd_of(p);
        q = back_of(p);
        if (n & 32'h10000)
            set_back(n & 32'hFFFF, q);
        if (q & 32'h10000)
            set_fwd(q & 32'hFFFF, n);
        else
            set_head(n);
    endfunction

    function automatic void swap_in(int unsigned p, int unsigned r);
        int unsigned n, q;
        n = fwd_of(p);
        q = back_of(p);
        set_fwd(r, n);
        set_back(r, q);
        if (n & 32'h10000)
            set_back(n & 32'hFFFF, r | 32'h10000);
        if (q & 32'h10000)
            set_fwd(q & 32'hFFFF, r | 32'h10000);
        else
            set_head(r | 32'h10000);
    endfunction

    function automatic void push_front(int unsigned p);
        int unsigned h;
        h = head_link();
        set_fwd(p, h);
        set_back(p, 0);
        if (h & 32'h10000)
            set_back(h & 32'hFFFF, p | 32'h10000);
        set_head(p | 32'h10000);
    endfunction

    function automatic void format_heap(logic [16:0] v);
        int unsigned u;
        u = 32'(v);
        if (u < 64) u = 64;
        if (u > POOL_BYTES) u = POOL_BYTES;
        u = u & ~32'hF;
        heap_used = u;
        foreach (heap_mem[i]) heap_mem[i] = '0;
        put_tag(0, 0, 1);
        put_tag(8, u - 32, 0);
        put_tag(u - 16, u - 32, 0);
        put_tag(u - 8, 0, 1);
        set_fwd(16, 0);
        set_back(16, 0);
        set_head(16 | 32'h10000);
    endfunction

    function automatic reply_t predict_alloc(logic [15:0] req);
        int unsigned sz, cur, p, s, rem, ftr;
        reply_t r;
        sz = req < 32 ? 32 : 32'(req);
        sz = (sz + 15) & ~32'hF;
        cur = head_link();
        for (int unsigned i = 0; i <= heap_used / 16 && (cur & 32'h10000); i++)
        begin
            p = cur & 32'hFFFF;
            s = 32'(heap_rd(p - 8));
            if (sz > s)
            begin
                cur = fwd_of(p);
                continue;
            end
            rem = s - sz;
            if (rem > 16)
            begin
                put_tag(p + sz + 8, rem - 16, 0);
                put_tag(p + s, rem - 16, 0);
                swap_in(p, p + sz + 16);
                ftr = p + sz;
            end
            else
            begin
                detach(p);
                sz = s;
                ftr = p + s;
            end
            put_tag(ftr, sz, 1);
            put_tag(p - 8, sz, 1);
            r.st = STAT_OK;
            r.off = p[15:0];
            return r;
        end
        r.st = STAT_NOFIT;
        r.off = '0;
        return r;
    endfunction

    function automatic reply_t predict_free(logic [15:0] o);
        logic [63:0] h, pt, nt;
        int unsigned off, hs, ps, ns, pp, np;
        bit pf, nf;
        reply_t r;
        off = 32'(o);
        r.off = '0;
        r.st = STAT_BADFREE;
        if ((off & 15) != 0 || off < 16)
            return r;
        h = heap_rd(off - 8);
        hs = h[31:0];
        if (!h[32] || hs == 0 || (hs & 15) != 0 || off + hs + 16 > heap_used
            || heap_rd(off + hs) != h)
            return r;
        r.st = STAT_OK;
        pt = heap_rd(off - 16);
        nt = heap_rd(off + hs + 8);
        ps = pt[31:0];
        ns = nt[31:0];
        pf = !pt[32];
        nf = !nt[32];
        pp = off - 16 - ps;
        np = off + hs + 16;
        if (!pf && !nf)
        begin
            put_tag(off - 8, hs, 0);
            put_tag(off + hs, hs, 0);
            push_front(off);
        end
        else if (pf && !nf)
        begin
            put_tag(pp - 8, ps + hs + 16, 0);
            put_tag(off + hs, ps + hs + 16, 0);
        end
        else if (!pf && nf)
        begin
            put_tag(off - 8, hs + ns + 16, 0);
            put_tag(np + ns, hs + ns + 16, 0);
            swap_in(np, off);
        end
        else
        begin
            detach(pp);
            detach(np);
            put_tag(pp - 8, ps + hs + ns + 32, 0);
            put_tag(np + ns, ps + hs + ns + 32, 0);
            push_front(pp);
        end
        return r;
    endfunction

    // called just after posedge; returns after acceptance and any idle gap
    task automatic send_request(logic act, logic [15:0] sz, logic [15:0] off,
                                bit chk, reply_t typed);
        reply_t r;
        in_valid <= 1'b1;
        action <= act;
        request_size <= sz;
        free_offset <= off;
        do @(posedge clk); while (in_stall);
        r = (act == ACT_FREE) ? predict_free(off) : predict_alloc(sz);
        replies_due.push_back(chk ? typed : r);
        if (r.st == STAT_OK && act == ACT_ALLOC)
            live_blocks.push_back(r.off);
        if (r.st == STAT_OK && act == ACT_FREE)
        begin
            foreach (live_blocks[i])
                if (live_blocks[i] == off)
                begin
                    live_blocks.delete(i);
                    break;
                end
            freed_blocks.push_back(off);
        end
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic write_pool_size(logic [16:0] v);
        in_valid <= 1'b0;
        wait (replies_due.size() == 0);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        format_heap(v);
        live_blocks.delete();
        freed_blocks.delete();
        @(posedge clk);
    endtask

    task automatic random_request();
        int unsigned r, k;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            k = $urandom_range(0, 19);
            v = k < 16 ? 16'($urandom_range(0, 300)) :
                k < 18 ? 16'($urandom_range(0, 4000)) :
                k < 19 ? 16'($urandom) : ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            send_request(ACT_ALLOC, v, 16'($urandom), 0, '0);
        end
        else if (r < 88 && live_blocks.size() != 0)
        begin
            v = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            send_request(ACT_FREE, 16'($urandom), v, 0, '0);
        end
        else
        begin
            k = $urandom_range(0, 2);
            if (k == 0 && freed_blocks.size() != 0)
                v = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
            else if (k == 1 && live_blocks.size() != 0)
                v = live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 16'd16;
            else
                v = 16'($urandom);
            send_request(ACT_FREE, 16'($urandom), v, 0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_cnt > 0)
        begin
            stall_cnt--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_cnt = $urandom_range(1, 18) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $error("unexpected response status=%0d offset=%0d", status, payload_offset);
                fails++;
            end
            else
            begin
                e = replies_due.pop_front();
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    fails++;
                end
                if (payload_offset !== e.off)
                begin
                    $error("payload_offset: expected %0d, got %0d", e.off, payload_offset);
                    fails++;
                end
            end
        end
    end

    dir_row_t dir_tab [22] = '{
        '{ACT_ALLOC, 16'd0,     16'd0,     1'b1, STAT_OK,      16'd16},
        '{ACT_ALLOC, 16'd65535, 16'd0,     1'b1, STAT_NOFIT,   16'd0},
        '{ACT_FREE,  16'd0,     16'd0,     1'b1, STAT_BADFREE, 16'd0},
        '{ACT_FREE,  16'd0,     16'd8,     1'b1, STAT_BADFREE, 16'd0},
        '{ACT_FREE,  16'hFFFF,  16'hFFFF,  1'b1, STAT_BADFREE, 16'd0},
        '{ACT_FREE,  16'd0,     16'd16,    1'b1, STAT_OK,      16'd0},
        '{ACT_FREE,  16'd0,     16'd16,    1'b1, STAT_BADFREE, 16'd0},
        '{ACT_ALLOC, 16'd1,     16'd0,     1'b1, STAT_OK,      16'd16},
        '{ACT_ALLOC, 16'd33,    16'd0,     1'b0, STAT_OK,      16'd0},
        '{ACT_ALLOC, 16'd100,   16'd0,     1'b0, STAT_OK,      16'd0},
        '{ACT_FREE,  16'd0,     16'd16,    1'b0, STAT_OK,      16'd0},
        '{ACT_FREE,  16'd0,     16'd128,   1'b0, STAT_OK,      16'd0},
        '{ACT_FREE,  16'd0,     16'd64,    1'b0, STAT_OK,      16'd0},
        '{ACT_ALLOC, 16'd65504, 16'd0,     1'b0, STAT_OK,      16'd0},
        '{ACT_ALLOC, 16'd16,    16'd0,     1'b1, STAT_NOFIT,   16'd0},
        '{ACT_FREE,  16'd0,     16'd16,    1'b0, STAT_OK,      16'd0},
        '{ACT_ALLOC, 16'd32,    16'd0,     1'b0, STAT_OK,      16'd0},
        '{ACT_ALLOC, 16'd32,    16'd0,     1'b0, STAT_OK,      16'd0},
        '{ACT_ALLOC, 16'd32,    16'd0,     1'b0, STAT_OK,      16'd0},
        '{ACT_FREE,  16'd0,     16'd16,    1'b0, STAT_OK,      16'd0},
        '{ACT_FREE,  16'd0,     16'd64,    1'b0, STAT_OK,      16'd0},
        '{ACT_FREE,  16'd0,     16'd112,   1'b0, STAT_OK,      16'd0}
    };

    initial
    begin
        format_heap(17'd65536);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_tab[i])
            send_request(dir_tab[i].act, dir_tab[i].sz, dir_tab[i].off, dir_tab[i].chk,
                         '{dir_tab[i].st, dir_tab[i].po});
        repeat (150) random_request();
        in_valid <= 1'b0;
        wait (replies_due.size() == 0);
        @(posedge clk);
        repeat (130) random_request();
        write_pool_size(17'd64);
        repeat (50) random_request();
        write_pool_size(17'd1024);
        repeat (150) random_request();
        write_pool_size(17'd100);
        repeat (40) random_request();
        write_pool_size(17'd4096);
        repeat (110) random_request();
        write_pool_size(17'h1FFFF);
        repeat (100) random_request();
        quiet = 1;
        repeat (100) random_request();
        in_valid <= 1'b0;
        wait (replies_due.size() == 0);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("first_fit_free_list_allocator_core: match");
        else
            $display("first_fit_free_list_allocator_core: mismatch");
        $finish;
    end

    initial
    begin
        #1000000000;
        $display("first_fit_free_list_allocator_core: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/ffla_pkg.sv
design/ffla_dp.sv
design/ffla_ctrl.sv
design/first_fit_free_list_allocator_core.sv
tb/tb.sv
